// ----- hdl/toggle_speaker_to_pcm_buffer_macros.svh -----
// Assertion macros for the speaker toggle to PCM buffer.
`ifndef TOGGLE_SPEAKER_TO_PCM_BUFFER_MACROS_SVH
`define TOGGLE_SPEAKER_TO_PCM_BUFFER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TSPB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSPB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tspb_pkg.sv -----
// Shared constants and types for the speaker toggle to PCM buffer.
`timescale 1ns / 1ps
package tspb_pkg;

  localparam int BufferDepth  = 4096;
  localparam int FractionBits = 15;
  localparam int AddrW        = $clog2(BufferDepth);
  localparam int CntW         = AddrW + 1;
  localparam int DataW        = 16;
  localparam int CycleW       = 32;
  localparam int ProdW        = CycleW + DataW;
  localparam int LeftW        = FractionBits + 1;
  localparam int CorrProdW    = DataW + LeftW;
  localparam int OneFrac      = 1 << FractionBits;
  localparam int CfgIdxW      = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStep = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgAmp  = 1'd1;

  localparam logic [DataW-1:0] StepReset = 16'd1445;
  localparam logic [DataW-1:0] AmpReset  = 16'd16384;

  typedef enum logic [1:0] {
    ModeToggle = 2'd0,
    ModeFlush  = 2'd1,
    ModeRead   = 2'd2,
    ModeResync = 2'd3
  } mode_e;

endpackage

// ----- hdl/toggle_speaker_to_pcm_buffer.sv -----
// Top level: speaker toggles to a 16-bit PCM frame held in one sample memory.
//
// Usage: one item at a time enters on the in channel (valid/ready), each gives
// exactly one result on the out channel. Modes: toggle, flush frame, read
// sample, resync. Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take
// effect at once and must be made only while the block is idle; the block
// itself does not enforce this. The single-port sample memory, written one
// sample a clock, sets the rate; a flush that ramps down over two samples or
// more also waits for the divider. in_ready_o is high only while no item is
// at work.
// The finished result sits in an output register: the next item may be
// accepted while it waits. If the receiver stalls and a second result is
// ready, the block holds it and accepts nothing more until out moves.
// Reset: level low, frame start cycle zero, no sample written, registers at
// their defaults. Sample memory contents are undefined until written; no
// clearing pass is run.
`timescale 1ns / 1ps
`include "toggle_speaker_to_pcm_buffer_macros.svh"
module toggle_speaker_to_pcm_buffer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [tspb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tspb_pkg::DataW-1:0]   cfg_wdata_i,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   mode_i,
  input  logic [tspb_pkg::CycleW-1:0]  cycle_now_i,
  input  logic [tspb_pkg::CntW-1:0]    sample_count_i,
  input  logic [tspb_pkg::AddrW-1:0]   read_index_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tspb_pkg::DataW-1:0]   sample_value_o,
  output logic                         speaker_level_o
);

  localparam int AddrW = tspb_pkg::AddrW;
  localparam int CntW  = tspb_pkg::CntW;
  localparam int DataW = tspb_pkg::DataW;
  localparam int FracB = tspb_pkg::FractionBits;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_POS    = 4'd2;
  localparam logic [3:0] S_CORR   = 4'd3;
  localparam logic [3:0] S_FILL   = 4'd4;
  localparam logic [3:0] S_RMW_RD = 4'd5;
  localparam logic [3:0] S_RMW_WR = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_RAMP   = 4'd8;
  localparam logic [3:0] S_RDW    = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  // Control state
  logic [3:0]                  state_q;
  logic [DataW-1:0]            step_q;
  logic [DataW-1:0]            amp_q;
  logic [tspb_pkg::CycleW-1:0] last_cycle_q;
  logic [AddrW-1:0]            lpos_q;
  logic                        none_q;
  logic                        level_q;
  logic                        out_valid_q;

  // Item and datapath registers
  tspb_pkg::mode_e             mode_q;
  logic [tspb_pkg::CycleW-1:0] now_q;
  logic [CntW-1:0]             cnt_in_q;
  logic [AddrW-1:0]            ridx_q;
  logic [tspb_pkg::ProdW-1:0]  prod_q;
  logic [AddrW-1:0]            pos_q;
  logic [tspb_pkg::LeftW-1:0]  left_q;
  logic [DataW-1:0]            corr_q;
  logic [CntW-1:0]             fill_i_q;
  logic [CntW-1:0]             limit_q;
  logic [AddrW-1:0]            end_q;
  logic [DataW-1:0]            quo_q;
  logic [AddrW-1:0]            remc_q;
  logic [DataW-1:0]            rq_q;
  logic [AddrW-1:0]            rr_q;
  logic [DataW-1:0]            res_value_q;
  logic [DataW-1:0]            sample_value_q;
  logic                        speaker_level_q;

  // Sample memory
  logic [DataW-1:0]            mem [tspb_pkg::BufferDepth];
  logic [DataW-1:0]            rdata_q;
  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr;
  logic [DataW-1:0]            mem_wdata;
  logic                        mem_re;
  logic [AddrW-1:0]            mem_raddr;

  // Combinational helpers
  logic                        in_xfer;
  logic                        out_load;
  logic [tspb_pkg::CycleW-1:0] elapsed;
  logic [tspb_pkg::ProdW-1:0]  prod_c;
  logic                        clamp;
  logic [AddrW-1:0]            pos_c;
  logic [tspb_pkg::LeftW-1:0]  left_c;
  logic [tspb_pkg::CorrProdW-1:0] corr_prod;
  logic [CntW-1:0]             cnt_clamp;
  logic [AddrW-1:0]            end_c;
  logic [CntW-1:0]             fill_start;
  logic [DataW-1:0]            level_val;
  logic                        fill_more;
  logic                        ramp_sel;
  logic                        div_start;
  logic                        div_done;
  logic [DataW-1:0]            div_quo;
  logic [AddrW-1:0]            div_rem;
  logic [AddrW:0]              rr_sum;
  logic                        rr_wrap;

  assign in_ready_o = state_q == S_IDLE;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = state_q == S_DONE && (!out_valid_q || out_ready_i);

  // Position and edge fraction
  assign elapsed   = now_q - last_cycle_q;
  assign prod_c    = tspb_pkg::ProdW'(elapsed) * tspb_pkg::ProdW'(step_q);
  assign clamp     = |prod_q[tspb_pkg::ProdW-1:FracB+AddrW];
  assign pos_c     = clamp ? '1 : prod_q[FracB+AddrW-1:FracB];
  assign left_c    = clamp ? '0
                   : tspb_pkg::LeftW'(tspb_pkg::OneFrac) - {1'b0, prod_q[FracB-1:0]};
  assign corr_prod = tspb_pkg::CorrProdW'(amp_q) * tspb_pkg::CorrProdW'(left_q);

  // Frame length and fill bounds
  assign cnt_clamp  = (cnt_in_q > CntW'(tspb_pkg::BufferDepth)) ?
                      CntW'(tspb_pkg::BufferDepth) : cnt_in_q;
  assign end_c      = AddrW'(cnt_clamp - CntW'(1));
  assign fill_start = none_q ? '0 : {1'b0, lpos_q} + CntW'(1);
  assign level_val  = level_q ? amp_q : '0;
  assign fill_more  = fill_i_q < limit_q;
  assign ramp_sel   = none_q && level_q;
  assign div_start  = state_q == S_DECODE && mode_q == tspb_pkg::ModeFlush && ramp_sel &&
                      cnt_clamp >= CntW'(2);

  // Ramp remainder step: one compare and subtract
  assign rr_sum  = {1'b0, rr_q} + {1'b0, remc_q};
  assign rr_wrap = rr_sum >= {1'b0, end_q};

  tspb_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (amp_q),
    .divisor_i   (end_c),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_i_q[AddrW-1:0];
    mem_wdata = level_val;
    mem_re    = 1'b0;
    mem_raddr = pos_q;
    case (state_q)
      S_FILL: begin
        mem_we = fill_more;
      end
      S_RAMP: begin
        mem_we    = fill_more;
        mem_wdata = amp_q - rq_q;
      end
      S_RMW_RD: begin
        mem_re = 1'b1;
      end
      S_RMW_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = level_q ? rdata_q + corr_q : rdata_q - corr_q;
      end
      S_DECODE: begin
        mem_re    = mode_q == tspb_pkg::ModeRead;
        mem_raddr = ridx_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Sequencer and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= tspb_pkg::StepReset;
      amp_q        <= tspb_pkg::AmpReset;
      last_cycle_q <= '0;
      lpos_q       <= '0;
      none_q       <= 1'b1;
      level_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tspb_pkg::CfgStep: step_q <= cfg_wdata_i;
          tspb_pkg::CfgAmp:  amp_q  <= cfg_wdata_i;
          default:           step_q <= step_q;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (mode_q)
            tspb_pkg::ModeToggle: state_q <= S_POS;
            tspb_pkg::ModeFlush: begin
              last_cycle_q <= now_q;
              none_q       <= 1'b1;
              if (ramp_sel) begin
                level_q <= 1'b0;
                state_q <= div_start ? S_DIV : S_RAMP;
              end else begin
                state_q <= S_FILL;
              end
            end
            tspb_pkg::ModeRead: state_q <= S_RDW;
            default: begin
              last_cycle_q <= now_q;
              none_q       <= 1'b1;
              level_q      <= 1'b0;
              state_q      <= S_DONE;
            end
          endcase
        end
        S_POS:  state_q <= S_CORR;
        S_CORR: state_q <= S_FILL;
        S_FILL: begin
          if (!fill_more) begin
            state_q <= (mode_q == tspb_pkg::ModeToggle) ? S_RMW_RD : S_DONE;
          end
        end
        S_RMW_RD: begin
          lpos_q  <= pos_q;
          none_q  <= 1'b0;
          level_q <= !level_q;
          state_q <= S_RMW_WR;
        end
        S_RMW_WR: state_q <= S_DONE;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_RAMP;
          end
        end
        S_RAMP: begin
          if (!fill_more) begin
            state_q <= S_DONE;
          end
        end
        S_RDW: state_q <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q   <= tspb_pkg::mode_e'(mode_i);
      now_q    <= cycle_now_i;
      cnt_in_q <= sample_count_i;
      ridx_q   <= read_index_i;
    end

    case (state_q)
      S_DECODE: begin
        res_value_q <= '0;
        prod_q      <= prod_c;
        end_q       <= end_c;
        limit_q     <= cnt_clamp;
        fill_i_q    <= ramp_sel ? '0 : fill_start;
        quo_q       <= '0;
        remc_q      <= '0;
        rq_q        <= '0;
        rr_q        <= '0;
      end
      S_POS: begin
        pos_q  <= pos_c;
        left_q <= left_c;
      end
      S_CORR: begin
        corr_q   <= corr_prod[FracB+DataW-1:FracB];
        fill_i_q <= fill_start;
        limit_q  <= {1'b0, pos_q} + CntW'(1);
      end
      S_FILL: begin
        if (fill_more) begin
          fill_i_q <= fill_i_q + CntW'(1);
        end
      end
      S_DIV: begin
        if (div_done) begin
          quo_q  <= div_quo;
          remc_q <= div_rem;
        end
      end
      S_RAMP: begin
        if (fill_more) begin
          fill_i_q <= fill_i_q + CntW'(1);
          if (rr_wrap) begin
            rr_q <= AddrW'(rr_sum - {1'b0, end_q});
            rq_q <= rq_q + quo_q + DataW'(1);
          end else begin
            rr_q <= rr_sum[AddrW-1:0];
            rq_q <= rq_q + quo_q;
          end
        end
      end
      S_RDW: begin
        res_value_q <= rdata_q;
      end
      default: begin
        res_value_q <= res_value_q;
      end
    endcase

    if (out_load) begin
      sample_value_q  <= res_value_q;
      speaker_level_q <= level_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_value_o  = sample_value_q;
  assign speaker_level_o = speaker_level_q;

  // Checks
  `TSPB_ASSERT_NXT(a_edge_rmw, state_q == S_RMW_RD, state_q == S_RMW_WR && !none_q,
    "edge read not followed by its write-back")
  `TSPB_ASSERT_IMP(a_ramp_range, state_q == S_RAMP && fill_more, rq_q <= amp_q,
    "ramp quotient exceeds amplitude")
  `TSPB_ASSERT_IMP(a_ramp_rem, state_q == S_RAMP && end_q != '0, rr_q < end_q,
    "ramp remainder not below ramp length")
  `TSPB_ASSERT_IMP(a_div_owner, div_done, state_q == S_DIV,
    "divider finished outside its wait state")

endmodule

// ----- hdl/tspb_div.sv -----
// Bit-serial restoring divider: amplitude over ramp length.
`timescale 1ns / 1ps
module tspb_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tspb_pkg::DataW-1:0] dividend_i,
  input  logic [tspb_pkg::AddrW-1:0] divisor_i,
  output logic                       done_o,
  output logic [tspb_pkg::DataW-1:0] quotient_o,
  output logic [tspb_pkg::AddrW-1:0] remainder_o
);

  localparam int StepW = $clog2(tspb_pkg::DataW + 1);

  logic                       busy_q;
  logic                       done_q;
  logic [StepW-1:0]           step_q;
  logic [tspb_pkg::DataW-1:0] dvd_q;
  logic [tspb_pkg::AddrW-1:0] dvs_q;
  logic [tspb_pkg::AddrW-1:0] rem_q;

  logic [tspb_pkg::AddrW:0]   trial;
  logic                       fits;

  // One quotient bit per cycle
  assign trial = {rem_q, dvd_q[tspb_pkg::DataW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(tspb_pkg::DataW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[tspb_pkg::DataW-2:0], fits};
      rem_q <= fits ? tspb_pkg::AddrW'(trial - {1'b0, dvs_q}) : trial[tspb_pkg::AddrW-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

// ----- test/toggle_speaker_to_pcm_buffer_tb.sv -----
// Self-checking testbench for the speaker toggle to PCM frame buffer.
`timescale 1ns / 1ps
module toggle_speaker_to_pcm_buffer_tb;

  localparam int DeadLimit = 20000;  // cycles with no transfer on either channel
  localparam int IdleGuard = 16;     // settle time before a register write or the end

  typedef struct packed {
    logic [tspb_pkg::DataW-1:0] sample;
    logic                       level;
  } pcm_result_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [tspb_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [tspb_pkg::DataW-1:0]    cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [1:0]                    mode_i;
  logic [tspb_pkg::CycleW-1:0]   cycle_now_i;
  logic [tspb_pkg::CntW-1:0]     sample_count_i;
  logic [tspb_pkg::AddrW-1:0]    read_index_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [tspb_pkg::DataW-1:0]    sample_value_o;
  logic                          speaker_level_o;

  // Predicted block state
  logic [tspb_pkg::DataW-1:0]    pcm_mem [tspb_pkg::BufferDepth];
  int                            written_top;   // entries 0..written_top have been written
  logic [tspb_pkg::CycleW-1:0]   frame_start;
  int                            last_pos;
  bit                            level;
  logic [tspb_pkg::DataW-1:0]    step_reg;
  logic [tspb_pkg::DataW-1:0]    amp_reg;

  pcm_result_t                   pcm_result_q[$];
  logic [tspb_pkg::CycleW-1:0]   cpu_cursor;
  bit                            steady_flow;
  int                            error_count;
  int                            dead_cycles;

  toggle_speaker_to_pcm_buffer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .cycle_now_i     (cycle_now_i),
    .sample_count_i  (sample_count_i),
    .read_index_i    (read_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sample_value_o  (sample_value_o),
    .speaker_level_o (speaker_level_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(string what, logic [tspb_pkg::DataW-1:0] got,
                                 logic [tspb_pkg::DataW-1:0] want);
    $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
    error_count++;
  endtask

  // Write the current level over a run of samples
  function automatic void fill_run(int first, int last);
    for (int i = first; i <= last; i++) begin
      if (i >= 0 && i < tspb_pkg::BufferDepth) pcm_mem[i] = level ? amp_reg : '0;
    end
    if (last > written_top) begin
      written_top = (last < tspb_pkg::BufferDepth) ? last : tspb_pkg::BufferDepth - 1;
    end
  endfunction

  // Apply one accepted item to the predicted state and queue its result
  task automatic apply_speaker_item(tspb_pkg::mode_e m, logic [tspb_pkg::CycleW-1:0] now,
                                    logic [tspb_pkg::CntW-1:0] cnt,
                                    logic [tspb_pkg::AddrW-1:0] idx);
    logic [tspb_pkg::CycleW-1:0] elapsed;
    logic [63:0]                 prod;
    logic [tspb_pkg::DataW-1:0]  left;
    logic [31:0]                 corr;
    logic [31:0]                 drop;
    logic [tspb_pkg::DataW-1:0]  value;
    int                          pos;
    int                          top;
    value = '0;
    case (m)
      tspb_pkg::ModeToggle: begin
        elapsed = now - frame_start;
        prod = {32'd0, elapsed} * {48'd0, step_reg};
        if (prod[63:tspb_pkg::FractionBits] >= tspb_pkg::BufferDepth) begin
          pos  = tspb_pkg::BufferDepth - 1;
          left = '0;
        end else begin
          pos  = int'(prod[tspb_pkg::FractionBits+tspb_pkg::AddrW-1:tspb_pkg::FractionBits]);
          left = 16'(tspb_pkg::OneFrac) - {1'b0, prod[tspb_pkg::FractionBits-1:0]};
        end
        fill_run(last_pos + 1, pos);
        last_pos = pos;
        level    = !level;
        // fractional correction on the edge sample, 16-bit wrap
        corr = ({16'd0, amp_reg} * {16'd0, left}) >> tspb_pkg::FractionBits;
        if (level) pcm_mem[pos] = pcm_mem[pos] + corr[tspb_pkg::DataW-1:0];
        else pcm_mem[pos] = pcm_mem[pos] - corr[tspb_pkg::DataW-1:0];
      end
      tspb_pkg::ModeFlush: begin
        top = ((cnt > tspb_pkg::BufferDepth) ? tspb_pkg::BufferDepth : int'(cnt)) - 1;
        if (last_pos == -1 && level) begin
          // nothing toggled while high: ramp down to zero
          level = 1'b0;
          for (int i = 0; i <= top; i++) begin
            if (top == 0) begin
              pcm_mem[i] = amp_reg;
            end else begin
              drop       = (32'(amp_reg) * 32'(i)) / 32'(top);
              pcm_mem[i] = amp_reg - drop[tspb_pkg::DataW-1:0];
            end
          end
          if (top > written_top) written_top = top;
        end else begin
          fill_run(last_pos + 1, top);
        end
        last_pos    = -1;
        frame_start = now;
      end
      tspb_pkg::ModeRead: begin
        value = pcm_mem[idx];
      end
      default: begin
        frame_start = now;
        last_pos    = -1;
        level       = 1'b0;
      end
    endcase
    pcm_result_q.push_back('{sample: value, level: level});
  endtask

  // Present one item after a random gap and hold it until the transfer
  task automatic send_item(tspb_pkg::mode_e m, logic [tspb_pkg::CycleW-1:0] now,
                           logic [tspb_pkg::CntW-1:0] cnt,
                           logic [tspb_pkg::AddrW-1:0] idx);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i         = m;
    cycle_now_i    = now;
    sample_count_i = cnt;
    read_index_i   = idx;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    apply_speaker_item(m, now, cnt, idx);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_block_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pcm_result_q.size() != 0) @(posedge clk_i);
    repeat (IdleGuard) @(negedge clk_i);
  endtask

  task automatic write_register(logic [tspb_pkg::CfgIdxW-1:0] idx,
                                logic [tspb_pkg::DataW-1:0] value);
    wait_block_idle();
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == tspb_pkg::CfgStep) step_reg = value;
    else amp_reg = value;
  endtask

  // Frames of forward toggles closed by flushes, with reads, resyncs and some noise
  task automatic run_random_items(int n_items);
    int                          roll;
    int                          incr_max;
    int                          cnt_max;
    logic [tspb_pkg::CycleW-1:0] cyc;
    logic [tspb_pkg::CntW-1:0]   cnt;
    cpu_cursor = frame_start;
    incr_max   = (step_reg == 0) ? 400 : (4 * tspb_pkg::OneFrac) / int'(step_reg);
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll >= 52 && roll < 72 && written_top < 0) roll = 0;
      if (roll < 45) begin
        cpu_cursor = cpu_cursor + $urandom_range(0, incr_max);
        send_item(tspb_pkg::ModeToggle, cpu_cursor, 13'($urandom), 12'($urandom));
      end else if (roll < 50) begin
        // lands at or behind the last toggle of this frame
        cyc = frame_start + $urandom_range(0, cpu_cursor - frame_start);
        send_item(tspb_pkg::ModeToggle, cyc, 13'($urandom), 12'($urandom));
      end else if (roll < 52) begin
        send_item(tspb_pkg::ModeToggle, $urandom, 13'($urandom), 12'($urandom));
      end else if (roll < 72) begin
        send_item(tspb_pkg::ModeRead, $urandom, 13'($urandom),
                  12'($urandom_range(0, written_top)));
      end else if (roll < 90) begin
        cnt_max = (last_pos < 0) ? 16 : last_pos + 12;
        if (cnt_max > tspb_pkg::BufferDepth) cnt_max = tspb_pkg::BufferDepth;
        cnt = ($urandom_range(0, 99) < 2) ? 13'(tspb_pkg::BufferDepth)
                                          : 13'($urandom_range(0, cnt_max));
        cyc = ($urandom_range(0, 3) == 0) ? $urandom : cpu_cursor + $urandom_range(0, 50);
        send_item(tspb_pkg::ModeFlush, cyc, cnt, 12'($urandom));
        cpu_cursor = cyc;
      end else begin
        cyc = ($urandom_range(0, 1) == 0) ? $urandom : cpu_cursor + $urandom_range(0, 50);
        send_item(tspb_pkg::ModeResync, cyc, 13'($urandom), 12'($urandom));
        cpu_cursor = cyc;
      end
    end
  endtask

  // Every mode, clamps, ramps, wrap of the cycle count, out-of-order toggles
  task automatic test_directed_cases();
    send_item(tspb_pkg::ModeToggle, 32'd100, '0, '0);
    send_item(tspb_pkg::ModeToggle, 32'd300, '0, '0);
    send_item(tspb_pkg::ModeToggle, 32'd200, '0, '0);          // behind the last write
    send_item(tspb_pkg::ModeRead, '0, '0, 12'd4);
    send_item(tspb_pkg::ModeRead, '1, '1, 12'd0);
    send_item(tspb_pkg::ModeFlush, 32'd1000, 13'd20, '1);
    send_item(tspb_pkg::ModeFlush, 32'd2000, 13'(tspb_pkg::BufferDepth), '0);  // full ramp
    send_item(tspb_pkg::ModeRead, '0, '0, 12'(tspb_pkg::BufferDepth - 1));
    send_item(tspb_pkg::ModeRead, '0, '0, 12'd2048);
    send_item(tspb_pkg::ModeRead, '0, '0, 12'd0);
    send_item(tspb_pkg::ModeToggle, 32'hFFFF_FFFF, '0, '0);    // position past the buffer
    send_item(tspb_pkg::ModeFlush, 32'd5000, 13'd1, '0);
    send_item(tspb_pkg::ModeFlush, 32'd6000, 13'd1, '0);       // ramp of one sample
    send_item(tspb_pkg::ModeRead, '0, '0, 12'd0);
    send_item(tspb_pkg::ModeToggle, 32'd6100, '0, '0);
    send_item(tspb_pkg::ModeFlush, 32'd7000, 13'd0, '0);
    send_item(tspb_pkg::ModeFlush, 32'd7100, 13'd0, '0);       // ramp with zero frame length
    send_item(tspb_pkg::ModeResync, 32'hFFFF_FFF0, '0, '0);
    send_item(tspb_pkg::ModeToggle, 32'h0000_0040, '0, '0);    // cycle count wraps
    send_item(tspb_pkg::ModeRead, '0, '0, 12'd3);
    send_item(tspb_pkg::ModeRead, '0, '0, 12'(tspb_pkg::BufferDepth - 1));
    send_item(tspb_pkg::ModeToggle, 32'hFFFF_FFF0, '0, '0);    // zero distance, full correction
    send_item(tspb_pkg::ModeResync, 32'd0, '0, '0);
  endtask

  task automatic test_register_extremes();
    write_register(tspb_pkg::CfgStep, 16'd0);
    write_register(tspb_pkg::CfgAmp, 16'd0);
    run_random_items(90);
    write_register(tspb_pkg::CfgStep, 16'hFFFF);
    write_register(tspb_pkg::CfgAmp, 16'hFFFF);
    run_random_items(90);
    // items with no gaps and a result sink that never stalls
    steady_flow = 1'b1;
    write_register(tspb_pkg::CfgStep, 16'd1);
    write_register(tspb_pkg::CfgAmp, 16'd1);
    run_random_items(90);
    steady_flow = 1'b0;
  endtask

  task automatic test_random_registers();
    repeat (2) begin
      write_register(tspb_pkg::CfgStep, 16'($urandom));
      write_register(tspb_pkg::CfgAmp, 16'($urandom));
      run_random_items(100);
    end
  endtask

  task automatic test_default_traffic();
    write_register(tspb_pkg::CfgStep, tspb_pkg::StepReset);
    write_register(tspb_pkg::CfgAmp, tspb_pkg::AmpReset);
    run_random_items(80);
  endtask

  // Result sink with random stalls
  initial begin : result_sink
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : check_results
    pcm_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pcm_result_q.size() == 0) begin
        report_mismatch("result with none pending", sample_value_o, '0);
      end else begin
        want = pcm_result_q.pop_front();
        if (sample_value_o !== want.sample)
          report_mismatch("sample_value", sample_value_o, want.sample);
        if (speaker_level_o !== want.level)
          report_mismatch("speaker_level", 16'(speaker_level_o), 16'(want.level));
      end
    end
  end

  // Watchdog on transfers
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      dead_cycles <= 0;
    end else begin
      dead_cycles <= dead_cycles + 1;
      if (dead_cycles >= DeadLimit) begin
        $display("toggle_speaker_to_pcm_buffer_tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = tspb_pkg::CfgStep;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    mode_i         = tspb_pkg::ModeToggle;
    cycle_now_i    = '0;
    sample_count_i = '0;
    read_index_i   = '0;
    steady_flow    = 1'b0;
    error_count    = 0;
    dead_cycles    = 0;
    written_top    = -1;
    frame_start    = '0;
    last_pos       = -1;
    level          = 1'b0;
    step_reg       = tspb_pkg::StepReset;
    amp_reg        = tspb_pkg::AmpReset;
    cpu_cursor     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_register_extremes();
    test_random_registers();
    test_default_traffic();

    wait_block_idle();
    if (error_count == 0) begin
      $display("toggle_speaker_to_pcm_buffer_tb passed");
    end else begin
      $display("toggle_speaker_to_pcm_buffer_tb failed");
    end
    $finish;
  end

endmodule

// ----- toggle_speaker_to_pcm_buffer.f -----
+incdir+hdl
hdl/tspb_pkg.sv
hdl/tspb_div.sv
hdl/toggle_speaker_to_pcm_buffer.sv
test/toggle_speaker_to_pcm_buffer_tb.sv
